/* hdl/huffman_code_table_builder_unit_macros.svh */
// Assertion macros for the Huffman code table builder
`ifndef HUFFMAN_CODE_TABLE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_UNIT_MACROS_SVH

// implication checked at every clock edge outside reset
`define HCB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("huffman code table builder check failed");

// plain check that also runs during reset
`define HCB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("huffman code table builder reset check failed");

`endif

/* hdl/hcb_pkg.sv */
// Shared types and constants of the Huffman code table builder
`default_nettype none
package hcb_pkg;
    localparam int SYMBOLS_DEF       = 256;
    localparam int MAX_CODE_BITS_DEF = 64;
    localparam int FREQ_W            = 32;
    localparam int SYM_BITS          = 8;
    localparam int LEN_W             = 7;
    localparam int CODE_W            = 64;
    localparam int USED_W            = 9;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_READ   = 1'b1;
    localparam logic RES_BUILD = 1'b0;
    localparam logic RES_READ  = 1'b1;

    typedef struct packed {
        logic clear;
        logic shift;
        logic insert;
    } chain_ctrl_t;
endpackage
`default_nettype wire

/* hdl/hcb_cell.sv */
// One cell of the sorted node chain: holds a node, inserts or shifts
`default_nettype none
module hcb_cell import hcb_pkg::*; #(
    parameter int WEIGHT_W = 40,
    parameter int ID_W     = 9
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire chain_ctrl_t         ctrl,
    input  wire logic [WEIGHT_W-1:0] new_w,
    input  wire logic [SYM_BITS-1:0] new_fs,
    input  wire logic [ID_W-1:0]     new_id,
    input  wire logic                prev_lt,
    input  wire logic                prev_valid,
    input  wire logic [WEIGHT_W-1:0] prev_w,
    input  wire logic [SYM_BITS-1:0] prev_fs,
    input  wire logic [ID_W-1:0]     prev_id,
    input  wire logic                next_valid,
    input  wire logic [WEIGHT_W-1:0] next_w,
    input  wire logic [SYM_BITS-1:0] next_fs,
    input  wire logic [ID_W-1:0]     next_id,
    output logic                     cell_valid,
    output logic [WEIGHT_W-1:0]      cell_w,
    output logic [SYM_BITS-1:0]      cell_fs,
    output logic [ID_W-1:0]          cell_id,
    output logic                     cell_lt
);
    logic                valid_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [SYM_BITS-1:0] fs_reg;
    logic [ID_W-1:0]     id_reg;

    // new key sorts ahead of this entry; an empty entry sorts last
    assign cell_lt = !valid_reg || (new_w < w_reg) || ((new_w == w_reg) && (new_fs < fs_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= next_valid;
        end else if (ctrl.insert) begin
            valid_reg <= prev_lt ? prev_valid : (cell_lt ? 1'b1 : valid_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            w_reg  <= next_w;
            fs_reg <= next_fs;
            id_reg <= next_id;
        end else if (ctrl.insert) begin
            if (prev_lt) begin
                w_reg  <= prev_w;
                fs_reg <= prev_fs;
                id_reg <= prev_id;
            end else if (cell_lt) begin
                w_reg  <= new_w;
                fs_reg <= new_fs;
                id_reg <= new_id;
            end
        end
    end

    assign cell_valid = valid_reg;
    assign cell_w     = w_reg;
    assign cell_fs    = fs_reg;
    assign cell_id    = id_reg;
endmodule
`default_nettype wire

/* hdl/hcb_chain.sv */
// Row of cells forming a sorted priority queue of live tree nodes
`default_nettype none
module hcb_chain import hcb_pkg::*; #(
    parameter int SYMBOLS  = SYMBOLS_DEF,
    parameter int WEIGHT_W = 40,
    parameter int ID_W     = 9
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire chain_ctrl_t         ctrl,
    input  wire logic [WEIGHT_W-1:0] new_w,
    input  wire logic [SYM_BITS-1:0] new_fs,
    input  wire logic [ID_W-1:0]     new_id,
    output logic [WEIGHT_W-1:0]      head0_w,
    output logic [SYM_BITS-1:0]      head0_fs,
    output logic [ID_W-1:0]          head0_id,
    output logic [WEIGHT_W-1:0]      head1_w,
    output logic [ID_W-1:0]          head1_id
);
    // index 0 and the last two are empty placeholders around the cells
    logic                valid_a [SYMBOLS+3];
    logic [WEIGHT_W-1:0] w_a     [SYMBOLS+3];
    logic [SYM_BITS-1:0] fs_a    [SYMBOLS+3];
    logic [ID_W-1:0]     id_a    [SYMBOLS+3];
    logic                lt_a    [SYMBOLS+1];

    assign valid_a[0] = 1'b0;
    assign w_a[0]     = '0;
    assign fs_a[0]    = '0;
    assign id_a[0]    = '0;
    assign lt_a[0]    = 1'b0;
    assign valid_a[SYMBOLS+1] = 1'b0;
    assign w_a[SYMBOLS+1]     = '0;
    assign fs_a[SYMBOLS+1]    = '0;
    assign id_a[SYMBOLS+1]    = '0;
    assign valid_a[SYMBOLS+2] = 1'b0;
    assign w_a[SYMBOLS+2]     = '0;
    assign fs_a[SYMBOLS+2]    = '0;
    assign id_a[SYMBOLS+2]    = '0;

    for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
        hcb_cell #(.WEIGHT_W(WEIGHT_W), .ID_W(ID_W)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_w      (new_w),
            .new_fs     (new_fs),
            .new_id     (new_id),
            .prev_lt    (lt_a[i]),
            .prev_valid (valid_a[i]),
            .prev_w     (w_a[i]),
            .prev_fs    (fs_a[i]),
            .prev_id    (id_a[i]),
            .next_valid (valid_a[i+3]),
            .next_w     (w_a[i+3]),
            .next_fs    (fs_a[i+3]),
            .next_id    (id_a[i+3]),
            .cell_valid (valid_a[i+1]),
            .cell_w     (w_a[i+1]),
            .cell_fs    (fs_a[i+1]),
            .cell_id    (id_a[i+1]),
            .cell_lt    (lt_a[i+1])
        );
    end

    assign head0_w  = w_a[1];
    assign head0_fs = fs_a[1];
    assign head0_id = id_a[1];
    assign head1_w  = w_a[2];
    assign head1_id = id_a[2];
endmodule
`default_nettype wire

/* hdl/huffman_code_table_builder_unit.sv */
// Huffman code table builder: frequency loads, tree build and code reads
// Usage:
//   Input requests (s_valid/s_ready) carry operation, symbol, frequency and
//   last_write. A write stores one symbol count and gives no result. A read
//   passes through the read state, and its answer is registered on m_* once
//   the output register is free; the next request is taken once it is loaded.
//   A write with last_write starts the build; s_ready is low until its status
//   result is loaded. The build sweeps the counts (at most one insertion into
//   the node chain per cycle), merges node pairs, walks the internal nodes
//   for the codes (node memory port) and fills the table entry of each used
//   symbol.
//   Result requests sit in an output register; while m_ready is low that
//   register holds and later writes are still accepted, while a read or build
//   waits for the register to free.
//   Reset (synchronous, aresetn low) clears counts and the code table through
//   valid flags.
`default_nettype none
module huffman_code_table_builder_unit import hcb_pkg::*; #(
    parameter int SYMBOLS       = SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire logic [SYM_BITS-1:0] s_symbol,
    input  wire logic [FREQ_W-1:0]   s_frequency,
    input  wire logic                s_last_write,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_result_kind,
    output logic [SYM_BITS-1:0]      m_out_symbol,
    output logic [LEN_W-1:0]         m_code_length,
    output logic [CODE_W-1:0]        m_code_bits,
    output logic [USED_W-1:0]        m_used_symbols
);
    localparam int SYM_W    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CNT_W    = $clog2(SYMBOLS + 1);
    localparam int NODES    = 2 * SYMBOLS - 1;
    localparam int ID_W     = $clog2(NODES);
    localparam int WEIGHT_W = FREQ_W + SYM_W;
    localparam int ENT_W    = LEN_W + CODE_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_SWEEP = 4'd2;
    localparam logic [3:0] ST_POP   = 4'd3;
    localparam logic [3:0] ST_INS   = 4'd4;
    localparam logic [3:0] ST_TR_A  = 4'd5;
    localparam logic [3:0] ST_TR_B  = 4'd6;
    localparam logic [3:0] ST_TR_C  = 4'd7;
    localparam logic [3:0] ST_LF_A  = 4'd8;
    localparam logic [3:0] ST_LF_B  = 4'd9;
    localparam logic [3:0] ST_RES   = 4'd10;

    logic [3:0] state_reg;

    // memories
    logic [FREQ_W-1:0]   count_mem [SYMBOLS];
    logic [ENT_W-1:0]    code_mem  [SYMBOLS];
    logic [SYM_W-1:0]    leaf_mem  [SYMBOLS];
    logic [2*ID_W-1:0]   child_mem [NODES];
    logic [ENT_W-1:0]    dc_mem    [NODES];

    logic [SYMBOLS-1:0]  cnt_vld_reg;
    logic [SYMBOLS-1:0]  code_vld_reg;

    logic [FREQ_W-1:0]   cq_reg;
    logic                cv_reg;
    logic                pv_reg;
    logic [SYM_W-1:0]    psym_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    leaves_reg;
    logic [ID_W-1:0]     nid_reg;
    logic [ID_W-1:0]     v_reg;
    logic [ID_W-1:0]     root_reg;
    logic [CNT_W-1:0]    s_reg;

    logic [ENT_W-1:0]    code_q_reg;
    logic                code_v_q_reg;
    logic                rd_hit_reg;
    logic [SYM_BITS-1:0] rd_sym_reg;
    logic [2*ID_W-1:0]   ch_q_reg;
    logic [ENT_W-1:0]    dc_q_reg;
    logic [SYM_W-1:0]    leaf_q_reg;

    logic [WEIGHT_W-1:0] a_w_reg, b_w_reg;
    logic [SYM_BITS-1:0] a_fs_reg;
    logic [ID_W-1:0]     a_id_reg, b_id_reg;
    logic [ID_W-1:0]     right_reg;
    logic [ENT_W-1:0]    dcr_reg;

    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [SYM_BITS-1:0] m_sym_reg;
    logic [LEN_W-1:0]    m_len_reg;
    logic [CODE_W-1:0]   m_bits_reg;
    logic [USED_W-1:0]   m_used_reg;

    logic                accept;
    logic                out_free;
    logic                sym_in;
    logic [SYM_W-1:0]    sym_idx;
    logic                leaf_ins;
    chain_ctrl_t         ctrl;
    logic [WEIGHT_W-1:0] new_w;
    logic [SYM_BITS-1:0] new_fs;
    logic [ID_W-1:0]     new_id;
    logic [WEIGHT_W-1:0] h0_w, h1_w;
    logic [SYM_BITS-1:0] h0_fs;
    logic [ID_W-1:0]     h0_id, h1_id;
    logic [CNT_W:0]      root_lim;
    logic [LEN_W-1:0]    cur_d;
    logic [CODE_W-1:0]   cur_c;
    logic [ENT_W-1:0]    dcl, dcr;
    logic [ID_W-1:0]     dc_raddr;
    logic                dc_we;
    logic [ID_W-1:0]     dc_waddr;
    logic [ENT_W-1:0]    dc_wdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sym_in   = ({1'b0, s_symbol} < 9'(SYMBOLS));
    assign sym_idx  = s_symbol[SYM_W-1:0];
    assign leaf_ins = (state_reg == ST_SWEEP) && pv_reg && cv_reg && (cq_reg != '0);
    assign root_lim = {1'b0, leaves_reg} + {1'b0, leaves_reg} - (CNT_W+1)'(2);

    always_comb begin
        ctrl.clear  = accept && (s_operation == OP_WRITE) && s_last_write;
        ctrl.shift  = (state_reg == ST_POP);
        ctrl.insert = leaf_ins || (state_reg == ST_INS);
        if (state_reg == ST_INS) begin
            new_w  = a_w_reg + b_w_reg;
            new_fs = a_fs_reg;
            new_id = nid_reg;
        end else begin
            new_w  = WEIGHT_W'(cq_reg);
            new_fs = SYM_BITS'(psym_reg);
            new_id = ID_W'(leaves_reg);
        end
    end

    hcb_chain #(.SYMBOLS(SYMBOLS), .WEIGHT_W(WEIGHT_W), .ID_W(ID_W)) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .new_w    (new_w),
        .new_fs   (new_fs),
        .new_id   (new_id),
        .head0_w  (h0_w),
        .head0_fs (h0_fs),
        .head0_id (h0_id),
        .head1_w  (h1_w),
        .head1_id (h1_id)
    );

    // code walk: root starts at depth 0, deeper codes saturate
    always_comb begin
        if (v_reg == root_reg) begin
            cur_d = '0;
            cur_c = '0;
        end else begin
            cur_d = dc_q_reg[ENT_W-1:CODE_W];
            cur_c = dc_q_reg[CODE_W-1:0];
        end
        if (cur_d < LEN_W'(MAX_CODE_BITS)) begin
            dcl = {cur_d + LEN_W'(1), cur_c << 1};
            dcr = {cur_d + LEN_W'(1), (cur_c << 1) | CODE_W'(1)};
        end else begin
            dcl = {cur_d, cur_c};
            dcr = {cur_d, cur_c};
        end
        dc_raddr = (state_reg == ST_LF_A) ? ID_W'(s_reg) : v_reg;
        dc_we    = (state_reg == ST_TR_B) || (state_reg == ST_TR_C);
        dc_waddr = (state_reg == ST_TR_B) ? ch_q_reg[2*ID_W-1:ID_W] : right_reg;
        dc_wdata = (state_reg == ST_TR_B) ? dcl : dcr_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_operation == OP_WRITE) && sym_in) begin
            count_mem[sym_idx] <= s_frequency;
        end
        cq_reg <= count_mem[scan_reg[SYM_W-1:0]];
    end

    // table entry is captured with the read request and held while it waits
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LF_B) begin
            code_mem[leaf_q_reg] <= (leaves_reg == CNT_W'(1)) ?
                {LEN_W'(1), CODE_W'(0)} : dc_q_reg;
        end
        if (accept) begin
            code_q_reg <= code_mem[sym_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (leaf_ins) begin
            leaf_mem[leaves_reg[SYM_W-1:0]] <= psym_reg;
        end
        leaf_q_reg <= leaf_mem[s_reg[SYM_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_INS) begin
            child_mem[nid_reg] <= {a_id_reg, b_id_reg};
        end
        ch_q_reg <= child_mem[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (dc_we) begin
            dc_mem[dc_waddr] <= dc_wdata;
        end
        dc_q_reg <= dc_mem[dc_raddr];
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        cv_reg       <= cnt_vld_reg[scan_reg[SYM_W-1:0]];
        psym_reg     <= scan_reg[SYM_W-1:0];
        if (accept) begin
            code_v_q_reg <= code_vld_reg[sym_idx];
            rd_hit_reg   <= sym_in;
            rd_sym_reg   <= s_symbol;
        end
        if (state_reg == ST_POP) begin
            a_w_reg  <= h0_w;
            a_fs_reg <= h0_fs;
            a_id_reg <= h0_id;
            b_w_reg  <= h1_w;
            b_id_reg <= h1_id;
        end
        if (state_reg == ST_TR_B) begin
            right_reg <= ch_q_reg[ID_W-1:0];
            dcr_reg   <= dcr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_vld_reg  <= '0;
            code_vld_reg <= '0;
            leaves_reg   <= '0;
            pv_reg       <= 1'b0;
            scan_reg     <= '0;
            nid_reg      <= '0;
            v_reg        <= '0;
            root_reg     <= '0;
            s_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (((state_reg == ST_READ) || (state_reg == ST_RES)) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_operation == OP_READ) begin
                            state_reg <= ST_READ;
                        end else begin
                            if (sym_in) begin
                                cnt_vld_reg[sym_idx] <= 1'b1;
                            end
                            if (s_last_write) begin
                                state_reg    <= ST_SWEEP;
                                scan_reg     <= '0;
                                pv_reg       <= 1'b0;
                                leaves_reg   <= '0;
                                code_vld_reg <= '0;
                            end
                        end
                    end
                end
                ST_READ: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    if (scan_reg < CNT_W'(SYMBOLS)) begin
                        scan_reg <= scan_reg + CNT_W'(1);
                        pv_reg   <= 1'b1;
                    end else begin
                        pv_reg <= 1'b0;
                    end
                    if (leaf_ins) begin
                        leaves_reg <= leaves_reg + CNT_W'(1);
                    end
                    if ((scan_reg == CNT_W'(SYMBOLS)) && !pv_reg) begin
                        cnt_vld_reg <= '0;
                        nid_reg     <= ID_W'(leaves_reg);
                        s_reg       <= '0;
                        if (leaves_reg == '0) begin
                            state_reg <= ST_RES;
                        end else if (leaves_reg == CNT_W'(1)) begin
                            state_reg <= ST_LF_A;
                        end else begin
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP: begin
                    state_reg <= ST_INS;
                end
                ST_INS: begin
                    nid_reg <= nid_reg + ID_W'(1);
                    if ((CNT_W+1)'(nid_reg) == root_lim) begin
                        v_reg     <= nid_reg;
                        root_reg  <= nid_reg;
                        state_reg <= ST_TR_A;
                    end else begin
                        state_reg <= ST_POP;
                    end
                end
                ST_TR_A: begin
                    state_reg <= ST_TR_B;
                end
                ST_TR_B: begin
                    state_reg <= ST_TR_C;
                end
                ST_TR_C: begin
                    if ((CNT_W+1)'(v_reg) == {1'b0, leaves_reg}) begin
                        s_reg     <= '0;
                        state_reg <= ST_LF_A;
                    end else begin
                        v_reg     <= v_reg - ID_W'(1);
                        state_reg <= ST_TR_A;
                    end
                end
                ST_LF_A: begin
                    state_reg <= ST_LF_B;
                end
                ST_LF_B: begin
                    code_vld_reg[leaf_q_reg] <= 1'b1;
                    s_reg <= s_reg + CNT_W'(1);
                    if (s_reg + CNT_W'(1) == leaves_reg) begin
                        state_reg <= ST_RES;
                    end else begin
                        state_reg <= ST_LF_A;
                    end
                end
                ST_RES: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (((state_reg == ST_READ) || (state_reg == ST_RES)) && out_free) begin
            m_used_reg <= USED_W'(leaves_reg);
            if (state_reg == ST_READ) begin
                m_kind_reg <= RES_READ;
                m_sym_reg  <= rd_sym_reg;
                if (rd_hit_reg && code_v_q_reg) begin
                    m_len_reg  <= code_q_reg[ENT_W-1:CODE_W];
                    m_bits_reg <= code_q_reg[CODE_W-1:0];
                end else begin
                    m_len_reg  <= '0;
                    m_bits_reg <= '0;
                end
            end else begin
                m_kind_reg <= RES_BUILD;
                m_sym_reg  <= '0;
                m_len_reg  <= '0;
                m_bits_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_out_symbol   = m_sym_reg;
    assign m_code_length  = m_len_reg;
    assign m_code_bits    = m_bits_reg;
    assign m_used_symbols = m_used_reg;
endmodule
`default_nettype wire

/* hdl/hcb_checker.sv */
// Port-level checks of the Huffman code table builder, bound to the top level
`default_nettype none
`include "huffman_code_table_builder_unit_macros.svh"
module hcb_checker import hcb_pkg::*; #(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic                m_result_kind,
    input wire logic [SYM_BITS-1:0] m_out_symbol,
    input wire logic [LEN_W-1:0]    m_code_length,
    input wire logic [CODE_W-1:0]   m_code_bits,
    input wire logic [USED_W-1:0]   m_used_symbols
);
    `HCB_ASSERT(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `HCB_ASSERT(a_build_zero, aclk, aresetn, m_valid && (m_result_kind == RES_BUILD) |-> (m_out_symbol == '0) && (m_code_length == '0) && (m_code_bits == '0))
    `HCB_ASSERT(a_absent_zero, aclk, aresetn, m_valid && (m_code_length == '0) |-> (m_code_bits == '0))
    `HCB_ASSERT(a_len_max, aclk, aresetn, m_valid |-> (m_code_length <= LEN_W'(MAX_CODE_BITS)) && (m_used_symbols <= USED_W'(256)))
    `HCB_ASSERT(a_busy_after_last, aclk, aresetn, s_valid && s_ready && m_valid && !m_ready |=> m_valid)
endmodule

bind huffman_code_table_builder_unit hcb_checker #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_hcb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_kind  (m_result_kind),
    .m_out_symbol   (m_out_symbol),
    .m_code_length  (m_code_length),
    .m_code_bits    (m_code_bits),
    .m_used_symbols (m_used_symbols)
);
`default_nettype wire

/* tb/tb_huffman_code_table_builder_unit.sv */
// Self-checking bench for the Huffman code table builder: directed table, then random builds
`default_nettype none
module tb_huffman_code_table_builder_unit;
    import hcb_pkg::*;

    localparam int NSYM  = 256;
    localparam int NNODE = 2 * NSYM - 1;
    localparam int RAND_ITEMS = 1550;

    typedef struct {
        logic                kind;
        logic [SYM_BITS-1:0] sym;
        logic [LEN_W-1:0]    len;
        logic [CODE_W-1:0]   bits;
        logic [USED_W-1:0]   used;
    } answer_t;

    typedef struct {
        logic                op;
        logic [SYM_BITS-1:0] sym;
        logic [FREQ_W-1:0]   freq;
        logic                last;
        bit                  typed;
        answer_t             ans;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_operation = OP_WRITE;
    logic [SYM_BITS-1:0] s_symbol = '0;
    logic [FREQ_W-1:0]   s_frequency = '0;
    logic                s_last_write = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_result_kind;
    logic [SYM_BITS-1:0] m_out_symbol;
    logic [LEN_W-1:0]    m_code_length;
    logic [CODE_W-1:0]   m_code_bits;
    logic [USED_W-1:0]   m_used_symbols;

    // predictor state
    logic [FREQ_W-1:0] sym_count [NSYM];
    logic [LEN_W-1:0]  tbl_len   [NSYM];
    logic [CODE_W-1:0] tbl_bits  [NSYM];
    logic [USED_W-1:0] tbl_used;
    logic [63:0]       nd_wt     [NNODE];
    logic [7:0]        nd_first  [NNODE];
    int                nd_left   [NNODE];
    int                nd_right  [NNODE];
    bit                nd_live   [NNODE];
    int                nd_depth  [NNODE];
    logic [63:0]       nd_code   [NNODE];

    answer_t pending_answers[$];
    int      errors = 0;
    int      results_seen = 0;
    int      builds_done = 0;
    int      reads_done = 0;
    int      items_sent = 0;

    always #6 aclk = ~aclk;

    huffman_code_table_builder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_symbol(s_symbol),
        .s_frequency(s_frequency), .s_last_write(s_last_write),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_kind(m_result_kind), .m_out_symbol(m_out_symbol),
        .m_code_length(m_code_length), .m_code_bits(m_code_bits),
        .m_used_symbols(m_used_symbols)
    );

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic bit earlier(int a, int b);
        if (nd_wt[a] != nd_wt[b]) return nd_wt[a] < nd_wt[b];
        return nd_first[a] < nd_first[b];
    endfunction

    function automatic int pop_lowest(int cnt);
        int best;
        best = -1;
        for (int i = 0; i < cnt; i++)
            if (nd_live[i] && (best < 0 || earlier(i, best))) best = i;
        if (best >= 0) nd_live[best] = 1'b0;
        return best;
    endfunction

    function automatic void build_codes();
        int leaves, cnt, a, b;
        leaves = 0;
        for (int s = 0; s < NSYM; s++) begin
            tbl_len[s] = '0;
            tbl_bits[s] = '0;
        end
        for (int i = 0; i < NNODE; i++) nd_live[i] = 1'b0;
        for (int s = 0; s < NSYM; s++)
            if (sym_count[s] != 0) begin
                nd_wt[leaves] = {32'd0, sym_count[s]};
                nd_first[leaves] = s[7:0];
                nd_live[leaves] = 1'b1;
                leaves++;
            end
        tbl_used = leaves[USED_W-1:0];
        for (int s = 0; s < NSYM; s++) sym_count[s] = '0;
        if (leaves == 0) return;
        if (leaves == 1) begin
            tbl_len[nd_first[0]] = LEN_W'(1);
            return;
        end
        cnt = leaves;
        while (cnt < 2 * leaves - 1) begin
            a = pop_lowest(cnt);
            b = pop_lowest(cnt);
            nd_wt[cnt] = nd_wt[a] + nd_wt[b];
            nd_first[cnt] = nd_first[a];
            nd_left[cnt] = a;
            nd_right[cnt] = b;
            nd_live[cnt] = 1'b1;
            cnt++;
        end
        nd_depth[cnt-1] = 0;
        nd_code[cnt-1] = '0;
        for (int v = cnt - 1; v >= leaves; v--) begin
            if (nd_depth[v] < MAX_CODE_BITS_DEF) begin
                nd_depth[nd_left[v]] = nd_depth[v] + 1;
                nd_depth[nd_right[v]] = nd_depth[v] + 1;
                nd_code[nd_left[v]] = nd_code[v] << 1;
                nd_code[nd_right[v]] = (nd_code[v] << 1) | 64'd1;
            end else begin
                nd_depth[nd_left[v]] = nd_depth[v];
                nd_depth[nd_right[v]] = nd_depth[v];
                nd_code[nd_left[v]] = nd_code[v];
                nd_code[nd_right[v]] = nd_code[v];
            end
        end
        for (int s = 0; s < leaves; s++) begin
            tbl_len[nd_first[s]] = nd_depth[s][LEN_W-1:0];
            tbl_bits[nd_first[s]] = nd_code[s];
        end
    endfunction

    // returns 1 when the request produces an answer
    function automatic bit predict_answer(row_t r, output answer_t ans);
        ans = '{default: '0};
        if (r.op == OP_WRITE) begin
            sym_count[r.sym] = r.freq;
            if (!r.last) return 1'b0;
            build_codes();
            ans.kind = RES_BUILD;
            ans.used = tbl_used;
            return 1'b1;
        end
        ans.kind = RES_READ;
        ans.sym = r.sym;
        ans.len = tbl_len[r.sym];
        ans.bits = tbl_bits[r.sym];
        ans.used = tbl_used;
        return 1'b1;
    endfunction

    // present one request after a random gap and wait for acceptance
    task automatic send_request(row_t r);
        int gap;
        answer_t ans;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= r.op;
        s_symbol <= r.sym;
        s_frequency <= r.freq;
        s_last_write <= r.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (predict_answer(r, ans)) begin
            if (r.typed) ans = r.ans;
            pending_answers = {pending_answers, ans};
            if (r.op == OP_WRITE) builds_done++;
            else reads_done++;
        end
    endtask

    function automatic row_t mk(logic op, int sym, logic [31:0] freq, logic last);
        row_t r;
        r = '{default: '0};
        r.op = op;
        r.sym = sym[7:0];
        r.freq = freq;
        r.last = last;
        return r;
    endfunction

    function automatic row_t mkx(logic op, int sym, logic [31:0] freq, logic last,
                                 logic kind, int esym, int len, logic [63:0] bits,
                                 int used);
        row_t r;
        r = mk(op, sym, freq, last);
        r.typed = 1'b1;
        r.ans.kind = kind;
        r.ans.sym = esym[7:0];
        r.ans.len = len[LEN_W-1:0];
        r.ans.bits = bits;
        r.ans.used = used[USED_W-1:0];
        return r;
    endfunction

    // result side: random stalls plus one long hold-off
    initial begin : receiver
        int wait_cycles;
        bit held;
        answer_t exp_ans;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            wait_cycles = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (!held && results_seen == 40) begin
                wait_cycles = 600;
                held = 1'b1;
            end
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            if (pending_answers.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                exp_ans = pending_answers.pop_front();
                if (m_result_kind !== exp_ans.kind)
                    report($sformatf("kind %0b exp %0b", m_result_kind, exp_ans.kind));
                if (m_out_symbol !== exp_ans.sym)
                    report($sformatf("symbol %0d exp %0d", m_out_symbol, exp_ans.sym));
                if (m_code_length !== exp_ans.len)
                    report($sformatf("sym %0d length %0d exp %0d", exp_ans.sym,
                                     m_code_length, exp_ans.len));
                if (m_code_bits !== exp_ans.bits)
                    report($sformatf("sym %0d bits %h exp %h", exp_ans.sym,
                                     m_code_bits, exp_ans.bits));
                if (m_used_symbols !== exp_ans.used)
                    report($sformatf("used %0d exp %0d", m_used_symbols, exp_ans.used));
            end
        end
    end

    initial begin : watchdog
        #200000000;
        $display("huffman_code_table_builder_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        row_t dir_rows[$];
        int written[$];
        int nsym, mode, nreads, sym;
        logic [31:0] f, fa, fb;

        for (int s = 0; s < NSYM; s++) begin
            sym_count[s] = '0;
            tbl_len[s] = '0;
            tbl_bits[s] = '0;
        end
        tbl_used = '0;

        // after reset, empty build, lone symbol, tie, extremes, overwrite to empty
        dir_rows = {dir_rows, mkx(OP_READ, 0, 32'h0, 0, RES_READ, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mkx(OP_WRITE, 0, 32'h0, 1, RES_BUILD, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mkx(OP_READ, 255, 32'hFFFFFFFF, 1, RES_READ, 255, 0, 0, 0)};
        dir_rows = {dir_rows, mkx(OP_WRITE, 255, 32'hFFFFFFFF, 1, RES_BUILD, 0, 0, 0, 1)};
        dir_rows = {dir_rows, mkx(OP_READ, 255, 32'h0, 0, RES_READ, 255, 1, 0, 1)};
        dir_rows = {dir_rows, mkx(OP_READ, 0, 32'h0, 0, RES_READ, 0, 0, 0, 1)};
        dir_rows = {dir_rows, mk(OP_WRITE, 0, 32'd5, 0)};
        dir_rows = {dir_rows, mkx(OP_WRITE, 1, 32'd5, 1, RES_BUILD, 0, 0, 0, 2)};
        dir_rows = {dir_rows, mkx(OP_READ, 0, 32'h0, 0, RES_READ, 0, 1, 0, 2)};
        dir_rows = {dir_rows, mkx(OP_READ, 1, 32'h0, 0, RES_READ, 1, 1, 1, 2)};
        dir_rows = {dir_rows, mk(OP_WRITE, 7, 32'hFFFFFFFF, 0)};
        dir_rows = {dir_rows, mk(OP_WRITE, 200, 32'd1, 0)};
        dir_rows = {dir_rows, mk(OP_WRITE, 100, 32'd1, 0)};
        dir_rows = {dir_rows, mk(OP_WRITE, 3, 32'h80000000, 1)};
        dir_rows = {dir_rows, mk(OP_READ, 7, 32'h0, 0)};
        dir_rows = {dir_rows, mk(OP_READ, 200, 32'h0, 0)};
        dir_rows = {dir_rows, mk(OP_READ, 100, 32'h0, 0)};
        dir_rows = {dir_rows, mk(OP_READ, 3, 32'h0, 0)};
        dir_rows = {dir_rows, mk(OP_WRITE, 5, 32'd9, 0)};
        dir_rows = {dir_rows, mkx(OP_WRITE, 5, 32'd0, 1, RES_BUILD, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mkx(OP_READ, 5, 32'h0, 0, RES_READ, 5, 0, 0, 0)};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_request(dir_rows[i]);

        while (items_sent < RAND_ITEMS) begin
            written.delete();
            if ($urandom_range(0, 19) == 0) nsym = NSYM;
            else nsym = $urandom_range(1, 24);
            mode = $urandom_range(0, 3);
            fa = 1;
            fb = 1;
            for (int k = 0; k < nsym; k++) begin
                sym = (nsym == NSYM) ? k : $urandom_range(0, 255);
                case (mode)
                    0: f = $urandom_range(1, 8);
                    1: f = $urandom;
                    2: begin
                        // Fibonacci weights make the deepest trees
                        f = fa;
                        if (fb < 32'd1836311903) begin
                            fa = fb;
                            fb = f + fb;
                        end
                    end
                    default: f = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 1000);
                endcase
                written = {written, sym};
                send_request(mk(OP_WRITE, sym, f, k == nsym - 1));
                // occasional read of the old table in the middle of loading
                if ($urandom_range(0, 15) == 0)
                    send_request(mk(OP_READ, $urandom_range(0, 255), $urandom, 0));
            end
            nreads = $urandom_range(1, 12);
            for (int k = 0; k < nreads; k++) begin
                if ($urandom_range(0, 4) == 0) sym = $urandom_range(0, 255);
                else sym = written[$urandom_range(0, written.size() - 1)];
                send_request(mk(OP_READ, sym, $urandom, $urandom_range(0, 1)));
            end
        end

        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Run: %0d requests, %0d builds, %0d code reads checked, %0d results.",
                 items_sent, builds_done, reads_done, results_seen);
        if (errors == 0)
            $display("huffman_code_table_builder_unit verification clean");
        else
            $display("huffman_code_table_builder_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/hcb_pkg.sv
hdl/hcb_cell.sv
hdl/hcb_chain.sv
hdl/huffman_code_table_builder_unit.sv
hdl/hcb_checker.sv
tb/tb_huffman_code_table_builder_unit.sv
